// ===== sv/rdi_pkg.sv =====
// shared types and constants for the ray / disk intersection pipeline
// no dependencies
`default_nettype none

package rdi_pkg;

    localparam int ACC_W = 64;

    typedef struct packed {
        logic en;
        logic valid;
    } t_ctl;

    typedef enum logic [2:0] {
        REG_CENTRE_X = 3'd0,
        REG_CENTRE_Y = 3'd1,
        REG_CENTRE_Z = 3'd2,
        REG_NORMAL_X = 3'd3,
        REG_NORMAL_Y = 3'd4,
        REG_NORMAL_Z = 3'd5,
        REG_RADIUS   = 3'd6
    } t_reg_idx;

endpackage

`default_nettype wire

// ===== sv/rdi_dot.sv =====
// front stages: centre minus origin, products with the normal, dot products
// depends on rdi_pkg
`default_nettype none

module rdi_dot #(
    parameter int W = 32,
    parameter int F = 16
) (
    input  wire                      i_clk,
    input  wire                      i_rst_n,
    input  rdi_pkg::t_ctl            i_ctl,
    input  wire logic signed [W-1:0] i_centre [3],
    input  wire logic signed [W-1:0] i_normal [3],
    input  wire logic signed [W-1:0] i_origin [3],
    input  wire logic signed [W-1:0] i_dir    [3],
    output logic                     o_valid,
    output logic signed [rdi_pkg::ACC_W-1:0] o_num,
    output logic signed [rdi_pkg::ACC_W-1:0] o_den,
    output logic signed [W-1:0]      o_origin [3],
    output logic signed [W-1:0]      o_dir    [3]
);

    localparam int AW = rdi_pkg::ACC_W;
    localparam int XW = (2 * W > AW) ? 2 * W : AW;

    function automatic logic signed [W-1:0] sat_w(input logic signed [W:0] v);
        if (v[W] == v[W-1]) return v[W-1:0];
        return v[W] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
    endfunction

    function automatic logic signed [AW-1:0] sat_p(input logic signed [XW-1:0] v);
        if ((&v[XW-1:AW-1]) || !(|v[XW-1:AW-1])) return v[AW-1:0];
        return v[XW-1] ? {1'b1, {(AW-1){1'b0}}} : {1'b0, {(AW-1){1'b1}}};
    endfunction

    function automatic logic signed [AW-1:0] sat_add(input logic signed [AW-1:0] a,
                                                     input logic signed [AW-1:0] b);
        logic signed [AW:0] s;
        s = {a[AW-1], a} + {b[AW-1], b};
        if (s[AW] == s[AW-1]) return s[AW-1:0];
        return s[AW] ? {1'b1, {(AW-1){1'b0}}} : {1'b0, {(AW-1){1'b1}}};
    endfunction

    logic                r_v1, r_v2, r_v3;
    logic signed [W-1:0] r_diff [3];
    logic signed [W-1:0] r_o1 [3], r_d1 [3], r_o2 [3], r_d2 [3], r_o3 [3], r_d3 [3];
    logic signed [AW-1:0] r_pn [3], r_pd [3];
    logic signed [AW-1:0] r_num, r_den;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else if (i_ctl.en) begin
            r_v1 <= i_ctl.valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en) begin
            for (int i = 0; i < 3; i++) begin
                r_diff[i] <= sat_w({i_centre[i][W-1], i_centre[i]}
                                   - {i_origin[i][W-1], i_origin[i]});
                r_o1[i]   <= i_origin[i];
                r_d1[i]   <= i_dir[i];
                r_pn[i]   <= sat_p(XW'(r_diff[i]) * XW'(i_normal[i]));
                r_pd[i]   <= sat_p(XW'(r_d1[i]) * XW'(i_normal[i]));
                r_o2[i]   <= r_o1[i];
                r_d2[i]   <= r_d1[i];
                r_o3[i]   <= r_o2[i];
                r_d3[i]   <= r_d2[i];
            end
            r_num <= sat_add(sat_add(r_pn[0] >>> F, r_pn[1] >>> F), r_pn[2] >>> F);
            r_den <= sat_add(sat_add(r_pd[0] >>> F, r_pd[1] >>> F), r_pd[2] >>> F);
        end
    end

    assign o_valid  = r_v3;
    assign o_num    = r_num;
    assign o_den    = r_den;
    assign o_origin = r_o3;
    assign o_dir    = r_d3;

endmodule

`default_nettype wire

// ===== sv/rdi_div.sv =====
// sign and overflow checks, then a restoring divider with one quotient bit per stage
// depends on rdi_pkg
`default_nettype none

module rdi_div #(
    parameter int W = 32,
    parameter int F = 16
) (
    input  wire                      i_clk,
    input  wire                      i_rst_n,
    input  rdi_pkg::t_ctl            i_ctl,
    input  wire logic signed [rdi_pkg::ACC_W-1:0] i_num,
    input  wire logic signed [rdi_pkg::ACC_W-1:0] i_den,
    input  wire logic signed [W-1:0] i_origin [3],
    input  wire logic signed [W-1:0] i_dir    [3],
    output logic                     o_valid,
    output logic [W-2:0]             o_t,
    output logic                     o_go,
    output logic signed [W-1:0]      o_origin [3],
    output logic signed [W-1:0]      o_dir    [3]
);

    localparam int AW = rdi_pkg::ACC_W;
    localparam int IB = W - 1 - F;
    localparam int RW = AW + W;
    localparam logic [W-2:0] TMAX = {(W-1){1'b1}};
    localparam logic [W-2:0] EPS  = (W-1)'(((64'd1 << F) + 64'd5000) / 64'd10000);

    typedef struct packed {
        logic zero;
        logic pos;
        logic ovf;
    } t_cls;

    logic                r_v   [W];
    t_cls                r_cls [W];
    logic [AW-1:0]       r_dm  [W];
    logic [RW-1:0]       r_rem [W];
    logic [W-2:0]        r_q   [W];
    logic signed [W-1:0] r_o   [W][3];
    logic signed [W-1:0] r_d   [W][3];

    logic [AW-1:0] nm, dm;

    always_comb begin
        nm = i_num[AW-1] ? AW'(-i_num) : AW'(i_num);
        dm = i_den[AW-1] ? AW'(-i_den) : AW'(i_den);
    end

    // classification stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else if (i_ctl.en) begin
            r_v[0] <= i_ctl.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en) begin
            r_cls[0].zero <= (i_den == '0);
            r_cls[0].pos  <= (i_num != '0) && (i_num[AW-1] == i_den[AW-1]);
            r_cls[0].ovf  <= (AW + IB)'(nm) >= ((AW + IB)'(dm) << IB);
            r_dm[0]       <= dm;
            r_rem[0]      <= RW'(nm) << F;
            r_q[0]        <= '0;
            r_o[0]        <= i_origin;
            r_d[0]        <= i_dir;
        end
    end

    for (genvar s = 1; s < W; s++) begin : g_bit
        localparam int J = W - 1 - s;
        logic [RW-1:0] sub;
        logic          ge;

        always_comb begin
            sub = RW'(r_dm[s-1]) << J;
            ge  = r_rem[s-1] >= sub;
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[s] <= 1'b0;
            end else if (i_ctl.en) begin
                r_v[s] <= r_v[s-1];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_ctl.en) begin
                r_rem[s] <= ge ? r_rem[s-1] - sub : r_rem[s-1];
                r_q[s]   <= r_q[s-1] | ((W-1)'(ge) << J);
                r_dm[s]  <= r_dm[s-1];
                r_cls[s] <= r_cls[s-1];
                r_o[s]   <= r_o[s-1];
                r_d[s]   <= r_d[s-1];
            end
        end
    end

    always_comb begin
        if (r_cls[W-1].zero) begin
            o_t = TMAX;
        end else if (r_cls[W-1].pos) begin
            o_t = r_cls[W-1].ovf ? TMAX : r_q[W-1];
        end else begin
            o_t = '0;
        end
        o_go = r_cls[W-1].pos && !r_cls[W-1].zero && !r_cls[W-1].ovf
               && (r_q[W-1] > EPS);
    end

    assign o_valid  = r_v[W-1];
    assign o_origin = r_o[W-1];
    assign o_dir    = r_d[W-1];

endmodule

`default_nettype wire

// ===== sv/rdi_point.sv =====
// back stages: hit point, squared distance to the centre, radius test, output register
// depends on rdi_pkg
`default_nettype none

module rdi_point #(
    parameter int W = 32,
    parameter int F = 16
) (
    input  wire                      i_clk,
    input  wire                      i_rst_n,
    input  rdi_pkg::t_ctl            i_ctl,
    input  wire logic [W-2:0]        i_t,
    input  wire logic                i_go,
    input  wire logic signed [W-1:0] i_origin [3],
    input  wire logic signed [W-1:0] i_dir    [3],
    input  wire logic signed [W-1:0] i_centre [3],
    input  wire logic [W-2:0]        i_radius,
    output logic                     o_valid,
    output logic                     o_hit,
    output logic [W-2:0]             o_t,
    output logic signed [W-1:0]      o_point [3]
);

    localparam int AW = rdi_pkg::ACC_W;
    localparam int XW = (2 * W > AW) ? 2 * W : AW;

    function automatic logic signed [W-1:0] sat_w(input logic signed [AW:0] v);
        if ((&v[AW:W-1]) || !(|v[AW:W-1])) return v[W-1:0];
        return v[AW] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
    endfunction

    function automatic logic signed [AW-1:0] sat_p(input logic signed [XW-1:0] v);
        if ((&v[XW-1:AW-1]) || !(|v[XW-1:AW-1])) return v[AW-1:0];
        return v[XW-1] ? {1'b1, {(AW-1){1'b0}}} : {1'b0, {(AW-1){1'b1}}};
    endfunction

    function automatic logic signed [AW-1:0] sat_add(input logic signed [AW-1:0] a,
                                                     input logic signed [AW-1:0] b);
        logic signed [AW:0] s;
        s = {a[AW-1], a} + {b[AW-1], b};
        if (s[AW] == s[AW-1]) return s[AW-1:0];
        return s[AW] ? {1'b1, {(AW-1){1'b0}}} : {1'b0, {(AW-1){1'b1}}};
    endfunction

    logic                 r_v1, r_v2, r_v3, r_v4, r_v5;
    logic [W-2:0]         r_t1, r_t2, r_t3, r_t4;
    logic                 r_g1, r_g2, r_g3, r_g4;
    logic signed [W-1:0]  r_o1 [3];
    logic signed [AW-1:0] r_pr [3];
    logic signed [W-1:0]  r_p2 [3], r_p3 [3], r_p4 [3];
    logic signed [W-1:0]  r_df [3];
    logic signed [AW-1:0] r_sq [3];
    logic signed [AW-1:0] r_r2;
    logic                 r_hit;
    logic [W-2:0]         r_t5;
    logic signed [W-1:0]  r_pt [3];

    logic signed [AW-1:0] sq_sum;
    logic                 hit;

    always_comb begin
        sq_sum = sat_add(sat_add(r_sq[0] >>> F, r_sq[1] >>> F), r_sq[2] >>> F);
        hit    = r_g4 && (sq_sum < r_r2);
    end

    // radius squared follows the register; the user must change it only while idle (not enforced)
    always_ff @(posedge i_clk) begin
        r_r2 <= sat_p(XW'($signed({1'b0, i_radius})) * XW'($signed({1'b0, i_radius})))
                >>> F;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
        end else if (i_ctl.en) begin
            r_v1 <= i_ctl.valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
            r_v5 <= r_v4;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en) begin
            for (int i = 0; i < 3; i++) begin
                r_pr[i] <= sat_p(XW'($signed({1'b0, i_t})) * XW'(i_dir[i]));
                r_o1[i] <= i_origin[i];
                r_p2[i] <= sat_w({1'b0, sat_add(AW'(r_o1[i]), r_pr[i] >>> F)}
                                 | {sat_add(AW'(r_o1[i]), r_pr[i] >>> F) < 0, {AW{1'b0}}});
                r_df[i] <= sat_w(AW'(r_p2[i]) - AW'(i_centre[i]) < 0
                                 ? {1'b1, AW'(r_p2[i]) - AW'(i_centre[i])}
                                 : {1'b0, AW'(r_p2[i]) - AW'(i_centre[i])});
                r_p3[i] <= r_p2[i];
                r_sq[i] <= sat_p(XW'(r_df[i]) * XW'(r_df[i]));
                r_p4[i] <= r_p3[i];
                r_pt[i] <= hit ? r_p4[i] : '0;
            end
            r_t1  <= i_t;
            r_g1  <= i_go;
            r_t2  <= r_t1;
            r_g2  <= r_g1;
            r_t3  <= r_t2;
            r_g3  <= r_g2;
            r_t4  <= r_t3;
            r_g4  <= r_g3;
            r_t5  <= r_t4;
            r_hit <= hit;
        end
    end

    assign o_valid = r_v5;
    assign o_hit   = r_hit;
    assign o_t     = r_t5;
    assign o_point = r_pt;

endmodule

`default_nettype wire

// ===== sv/ray_disk_intersect.sv =====
// top level of the ray / disk intersection pipeline: register file, flow control
// depends on rdi_pkg, rdi_dot, rdi_div, rdi_point
//
// channel   direction  handshake                 contents
// ray in    input      i_valid / o_stall         origin and direction
// result    output     o_valid / i_stall         hit flag, distance, point
// config    input      i_cfg_valid / o_cfg_ready register index and data
//
// one transaction per clock while the result is not stalled; the divider
// resolves one quotient bit per stage
// synchronous active-low reset clears the valid bits and loads the register defaults
// a stalled result freezes the whole pipeline; o_stall follows at once
`default_nettype none

module ray_disk_intersect #(
    parameter int FRAC_BITS   = 16,
    parameter int COORD_WIDTH = 32
) (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    input  wire                                i_valid,
    output logic                               o_stall,
    input  wire logic signed [COORD_WIDTH-1:0] i_origin_x,
    input  wire logic signed [COORD_WIDTH-1:0] i_origin_y,
    input  wire logic signed [COORD_WIDTH-1:0] i_origin_z,
    input  wire logic signed [COORD_WIDTH-1:0] i_dir_x,
    input  wire logic signed [COORD_WIDTH-1:0] i_dir_y,
    input  wire logic signed [COORD_WIDTH-1:0] i_dir_z,
    output logic                               o_valid,
    input  wire                                i_stall,
    output logic                               o_is_hit,
    output logic [COORD_WIDTH-2:0]             o_hit_distance,
    output logic signed [COORD_WIDTH-1:0]      o_point_x,
    output logic signed [COORD_WIDTH-1:0]      o_point_y,
    output logic signed [COORD_WIDTH-1:0]      o_point_z,
    input  wire                                i_cfg_valid,
    output logic                               o_cfg_ready,
    input  wire logic [2:0]                    i_cfg_index,
    input  wire logic [COORD_WIDTH-1:0]        i_cfg_data
);

    localparam int W = COORD_WIDTH;
    localparam int F = FRAC_BITS;
    localparam int AW = rdi_pkg::ACC_W;

    logic signed [W-1:0] r_centre [3];
    logic signed [W-1:0] r_normal [3];
    logic [W-2:0]        r_radius;

    logic                en;
    rdi_pkg::t_ctl       ctl_in, ctl_run;
    logic signed [W-1:0] org [3], dir [3];

    logic                 dot_valid;
    logic signed [AW-1:0] dot_num, dot_den;
    logic signed [W-1:0]  dot_o [3], dot_d [3];

    logic                div_valid;
    logic [W-2:0]        div_t;
    logic                div_go;
    logic signed [W-1:0] div_o [3], div_d [3];

    logic signed [W-1:0] pt [3];

    assign en          = !o_valid || !i_stall;
    assign o_stall     = !en;
    assign o_cfg_ready = 1'b1;

    assign org = '{i_origin_x, i_origin_y, i_origin_z};
    assign dir = '{i_dir_x, i_dir_y, i_dir_z};

    always_comb begin
        ctl_in.en     = en;
        ctl_in.valid  = i_valid;
        ctl_run.en    = en;
        ctl_run.valid = 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_centre <= '{'0, '0, '0};
            r_normal <= '{'0, W'(6554), '0};
            r_radius <= (W-1)'(65536);
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (rdi_pkg::t_reg_idx'(i_cfg_index))
                rdi_pkg::REG_CENTRE_X: r_centre[0] <= i_cfg_data;
                rdi_pkg::REG_CENTRE_Y: r_centre[1] <= i_cfg_data;
                rdi_pkg::REG_CENTRE_Z: r_centre[2] <= i_cfg_data;
                rdi_pkg::REG_NORMAL_X: r_normal[0] <= i_cfg_data;
                rdi_pkg::REG_NORMAL_Y: r_normal[1] <= i_cfg_data;
                rdi_pkg::REG_NORMAL_Z: r_normal[2] <= i_cfg_data;
                rdi_pkg::REG_RADIUS:   r_radius    <= i_cfg_data[W-2:0];
                default: ;
            endcase
        end
    end

    rdi_dot #(.W(W), .F(F)) u_dot (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (ctl_in),
        .i_centre (r_centre),
        .i_normal (r_normal),
        .i_origin (org),
        .i_dir    (dir),
        .o_valid  (dot_valid),
        .o_num    (dot_num),
        .o_den    (dot_den),
        .o_origin (dot_o),
        .o_dir    (dot_d)
    );

    rdi_div #(.W(W), .F(F)) u_div (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    ('{en: ctl_run.en, valid: dot_valid}),
        .i_num    (dot_num),
        .i_den    (dot_den),
        .i_origin (dot_o),
        .i_dir    (dot_d),
        .o_valid  (div_valid),
        .o_t      (div_t),
        .o_go     (div_go),
        .o_origin (div_o),
        .o_dir    (div_d)
    );

    rdi_point #(.W(W), .F(F)) u_point (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    ('{en: ctl_run.en, valid: div_valid}),
        .i_t      (div_t),
        .i_go     (div_go),
        .i_origin (div_o),
        .i_dir    (div_d),
        .i_centre (r_centre),
        .i_radius (r_radius),
        .o_valid  (o_valid),
        .o_hit    (o_is_hit),
        .o_t      (o_hit_distance),
        .o_point  (pt)
    );

    assign o_point_x = pt[0];
    assign o_point_y = pt[1];
    assign o_point_z = pt[2];

endmodule

`default_nettype wire
